FILE: hw/rtl/rgbmip_pkg.sv
// shared constants for the rgba8 box mip downsample unit
`default_nettype none

package rgbmip_pkg;

	localparam int DefMaxSrcWidth  = 4096;
	localparam int DefMaxSrcHeight = 4096;

	localparam int ChanW    = 8;
	localparam int RunW     = 10;
	localparam int SumW     = 12;
	localparam int MipW     = 11;
	localparam int CfgIdxW  = 8;
	localparam int CfgDataW = 13;
	localparam int InDataW  = 32;
	localparam int OutDataW = 56;

	localparam logic [CfgIdxW-1:0] RegSrcWidth  = CfgIdxW'(0);
	localparam logic [CfgIdxW-1:0] RegSrcHeight = CfgIdxW'(1);

	// reciprocals scaled by 2^16 for the footprint sample counts
	localparam int RecipShift = 16;
	localparam logic [16:0] Recip1 = 17'd65536;
	localparam logic [16:0] Recip2 = 17'd32768;
	localparam logic [16:0] Recip3 = 17'd21846;
	localparam logic [16:0] Recip4 = 17'd16384;
	localparam logic [16:0] Recip6 = 17'd10923;
	localparam logic [16:0] Recip9 = 17'd7282;

endpackage

`default_nettype wire

FILE: hw/rtl/rgbmip_ram.sv
// generic single-write, single-read synchronous ram with registered read
`default_nettype none

module rgbmip_ram #(
	parameter int DATA_W = 48,
	parameter int DEPTH  = 2048,
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [AW-1:0]     waddr,
	input  wire logic [DATA_W-1:0] wdata,
	input  wire logic              re,
	input  wire logic [AW-1:0]     raddr,
	output logic      [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

FILE: hw/rtl/rgba8_box_mip_downsample_unit.sv
// rgba8 box filter mip level builder, streaming top level
//
//  channel   dir  handshake                      contents
//  s_axis    in   s_axis_tvalid / s_axis_tready  one source pixel in raster order
//  m_axis    out  m_axis_tvalid / m_axis_tready  one mip pixel, tlast on last of level
//  cfg       in   cfg_valid / cfg_ready          register index and write data
//
// one source beat per cycle while m_axis is not stalled; a mip pixel passes the
// s1 and s2 stages and the output register after the beat that closes its
// footprint. the column accumulator ram (one read and one write port) is touched once per closed column footprint.
// no clearing pass after reset: the first row of each footprint overwrites.
// a stalled m_axis holds every stage and the input.
`default_nettype none

module rgba8_box_mip_downsample_unit #(
	parameter int MAX_SRC_WIDTH  = rgbmip_pkg::DefMaxSrcWidth,
	parameter int MAX_SRC_HEIGHT = rgbmip_pkg::DefMaxSrcHeight
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           s_axis_tvalid,
	output logic                                s_axis_tready,
	// red, green, blue, alpha
	input  wire logic [rgbmip_pkg::InDataW-1:0] s_axis_tdata,
	output logic                                m_axis_tvalid,
	input  wire logic                           m_axis_tready,
	// out_red, out_green, out_blue, out_alpha, mip_col, mip_row, zero pad
	output logic [rgbmip_pkg::OutDataW-1:0]     m_axis_tdata,
	// level_done
	output logic                                m_axis_tlast,
	input  wire logic                           cfg_valid,
	output logic                                cfg_ready,
	input  wire logic [rgbmip_pkg::CfgIdxW-1:0] cfg_index,
	input  wire logic [rgbmip_pkg::CfgDataW-1:0] cfg_data
);

	import rgbmip_pkg::*;

	localparam int CW    = $clog2(MAX_SRC_WIDTH + 1);
	localparam int RW    = $clog2(MAX_SRC_HEIGHT + 1);
	localparam int SzW   = (CW > RW) ? CW : RW;
	localparam int MDEP  = MAX_SRC_WIDTH / 2;
	localparam int MCW   = (MDEP > 1) ? $clog2(MDEP) : 1;
	localparam int MRDEP = MAX_SRC_HEIGHT / 2;
	localparam int MRW   = (MRDEP > 1) ? $clog2(MRDEP) : 1;
	localparam int PrW   = SumW + 17;

	typedef logic [3:0][RunW-1:0] run_t;
	typedef logic [3:0][SumW-1:0] sum_t;

	function automatic logic [SzW-1:0] clamp_size(input logic [CfgDataW-1:0] v, input int maxv);
		logic [31:0] vv;
		vv = 32'(v);
		if (vv == 32'd0) begin
			return SzW'(1);
		end else if (vv > 32'(maxv)) begin
			return SzW'(maxv);
		end
		return SzW'(vv);
	endfunction

	function automatic logic [1:0] fp_step(input logic [SzW-1:0] s);
		return (s < SzW'(4)) ? s[1:0] : 2'd2;
	endfunction

	function automatic logic fp_rem(input logic [SzW-1:0] s);
		return (s < SzW'(4)) ? 1'b0 : s[0];
	endfunction

	function automatic logic [ChanW-1:0] div_count(input logic [SumW-1:0] x,
		input logic [3:0] n);
		logic [16:0]    recip;
		logic [PrW-1:0] prod;
		case (n)
			4'd1:    recip = Recip1;
			4'd2:    recip = Recip2;
			4'd3:    recip = Recip3;
			4'd4:    recip = Recip4;
			4'd6:    recip = Recip6;
			4'd9:    recip = Recip9;
			default: recip = Recip1;
		endcase
		prod = PrW'(x) * PrW'(recip);
		return ChanW'(prod >> RecipShift);
	endfunction

	// configuration and position state
	logic [CW-1:0]  width_q, src_col_q, col_begin_q, col_end_q, col_rem_q;
	logic [RW-1:0]  height_q, src_row_q, row_begin_q, row_end_q, row_rem_q;
	logic [MCW-1:0] mcol_q;
	logic [MRW-1:0] mrow_q;
	run_t           run_q;

	// pipeline
	logic           v_s1, v_s2, m_valid_q;
	run_t           run_s1;
	logic           first_s1, emit_s1, done_s1, fwd_hit_s1, done_s2;
	logic [3:0]     n_s1, n_s2;
	logic [MCW-1:0] mcol_s1;
	logic [MRW-1:0] mrow_s1;
	sum_t           fwd_data_s1, biased_s2;
	logic [MipW-1:0] mcol_s2, mrow_s2;
	logic [OutDataW-1:0] m_data_q;
	logic           m_last_q;

	logic           adv, accept, restart;
	logic [SzW-1:0] nxt_w, nxt_h;
	logic [CW-1:0]  mw, col_rem_inc, col_end_adv, col_rem_adv;
	logic [RW-1:0]  mh, row_rem_inc, row_end_adv, row_rem_adv;
	logic [1:0]     col_step, row_step, ncol, nrow;
	logic           col_r, row_r, col_carry, row_carry;
	logic           col_first, col_last, row_first, row_last, row_wrap, frame_wrap;
	run_t           run_nxt;
	sum_t           ram_rdata, base_s1, total_s1;
	logic           lvl_done;

	assign cfg_ready     = 1'b1;
	assign adv           = !m_valid_q || m_axis_tready;
	assign s_axis_tready = adv;
	assign accept        = s_axis_tvalid && adv;
	assign restart       = cfg_valid && (cfg_index == RegSrcWidth || cfg_index == RegSrcHeight);

	assign nxt_w = (cfg_valid && cfg_index == RegSrcWidth) ?
		clamp_size(cfg_data, MAX_SRC_WIDTH) : SzW'(width_q);
	assign nxt_h = (cfg_valid && cfg_index == RegSrcHeight) ?
		clamp_size(cfg_data, MAX_SRC_HEIGHT) : SzW'(height_q);

	assign mw = ((width_q >> 1) > CW'(1)) ? (width_q >> 1) : CW'(1);
	assign mh = ((height_q >> 1) > RW'(1)) ? (height_q >> 1) : RW'(1);

	assign col_step = fp_step(SzW'(width_q));
	assign col_r    = fp_rem(SzW'(width_q));
	assign row_step = fp_step(SzW'(height_q));
	assign row_r    = fp_rem(SzW'(height_q));

	// footprint end stepping without a divider
	assign col_rem_inc = col_rem_q + CW'(col_r);
	assign col_carry   = col_rem_inc >= mw;
	assign col_end_adv = col_end_q + CW'(col_step) + CW'(col_carry);
	assign col_rem_adv = col_carry ? col_rem_inc - mw : col_rem_inc;
	assign row_rem_inc = row_rem_q + RW'(row_r);
	assign row_carry   = row_rem_inc >= mh;
	assign row_end_adv = row_end_q + RW'(row_step) + RW'(row_carry);
	assign row_rem_adv = row_carry ? row_rem_inc - mh : row_rem_inc;

	assign col_first  = src_col_q == col_begin_q;
	assign col_last   = src_col_q + CW'(1) == col_end_q;
	assign row_first  = src_row_q == row_begin_q;
	assign row_last   = src_row_q + RW'(1) == row_end_q;
	assign row_wrap   = src_col_q + CW'(1) >= width_q;
	assign frame_wrap = src_row_q + RW'(1) >= height_q;
	assign ncol       = 2'(col_end_q - col_begin_q);
	assign nrow       = 2'(row_end_q - row_begin_q);
	assign lvl_done   = (CW'(mcol_q) + CW'(1) == mw) && (RW'(mrow_q) + RW'(1) == mh);

	always_comb begin
		for (int k = 0; k < 4; k++) begin
			run_nxt[k] = col_first ? RunW'(s_axis_tdata[k*ChanW +: ChanW]) :
				run_q[k] + RunW'(s_axis_tdata[k*ChanW +: ChanW]);
		end
	end

	always_comb begin
		base_s1 = fwd_hit_s1 ? fwd_data_s1 : ram_rdata;
		for (int k = 0; k < 4; k++) begin
			total_s1[k] = first_s1 ? SumW'(run_s1[k]) : base_s1[k] + SumW'(run_s1[k]);
		end
	end

	rgbmip_ram #(
		.DATA_W(4 * SumW),
		.DEPTH (MDEP)
	) u_col_sums (
		.clk  (clk),
		.we   (v_s1 && adv),
		.waddr(mcol_s1),
		.wdata(total_s1),
		.re   (accept && col_last),
		.raddr(mcol_q),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q     <= CW'(1);
			height_q    <= RW'(1);
			src_col_q   <= '0;
			src_row_q   <= '0;
			mcol_q      <= '0;
			mrow_q      <= '0;
			col_begin_q <= '0;
			col_end_q   <= CW'(1);
			col_rem_q   <= '0;
			row_begin_q <= '0;
			row_end_q   <= RW'(1);
			row_rem_q   <= '0;
			run_q       <= '0;
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			m_valid_q   <= 1'b0;
		end else begin
			if (restart) begin
				width_q     <= CW'(nxt_w);
				height_q    <= RW'(nxt_h);
				src_col_q   <= '0;
				src_row_q   <= '0;
				mcol_q      <= '0;
				mrow_q      <= '0;
				col_begin_q <= '0;
				col_end_q   <= CW'(fp_step(nxt_w));
				col_rem_q   <= CW'(fp_rem(nxt_w));
				row_begin_q <= '0;
				row_end_q   <= RW'(fp_step(nxt_h));
				row_rem_q   <= RW'(fp_rem(nxt_h));
				run_q       <= '0;
			end else if (accept) begin
				run_q     <= run_nxt;
				src_col_q <= src_col_q + CW'(1);
				if (col_last) begin
					mcol_q      <= mcol_q + MCW'(1);
					col_begin_q <= col_end_q;
					col_end_q   <= col_end_adv;
					col_rem_q   <= col_rem_adv;
				end
				if (row_wrap) begin
					src_col_q   <= '0;
					mcol_q      <= '0;
					col_begin_q <= '0;
					col_end_q   <= CW'(col_step);
					col_rem_q   <= CW'(col_r);
					src_row_q   <= src_row_q + RW'(1);
					if (row_last) begin
						mrow_q      <= mrow_q + MRW'(1);
						row_begin_q <= row_end_q;
						row_end_q   <= row_end_adv;
						row_rem_q   <= row_rem_adv;
					end
					if (frame_wrap) begin
						src_row_q   <= '0;
						mrow_q      <= '0;
						row_begin_q <= '0;
						row_end_q   <= RW'(row_step);
						row_rem_q   <= RW'(row_r);
					end
				end
			end
			if (adv) begin
				v_s1      <= accept && col_last;
				v_s2      <= v_s1 && emit_s1;
				m_valid_q <= v_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			if (accept && col_last) begin
				run_s1      <= run_nxt;
				first_s1    <= row_first;
				emit_s1     <= row_last;
				done_s1     <= lvl_done;
				n_s1        <= 4'(ncol) * 4'(nrow);
				mcol_s1     <= mcol_q;
				mrow_s1     <= mrow_q;
				// same-edge write to this entry is not in the ram read data
				fwd_hit_s1  <= v_s1 && (mcol_s1 == mcol_q);
				fwd_data_s1 <= total_s1;
			end
			for (int k = 0; k < 4; k++) begin
				biased_s2[k] <= total_s1[k] + SumW'(n_s1 >> 1);
			end
			n_s2    <= n_s1;
			mcol_s2 <= MipW'(mcol_s1);
			mrow_s2 <= MipW'(mrow_s1);
			done_s2 <= done_s1;
			m_data_q <= {2'b00, mrow_s2, mcol_s2,
				div_count(biased_s2[3], n_s2), div_count(biased_s2[2], n_s2),
				div_count(biased_s2[1], n_s2), div_count(biased_s2[0], n_s2)};
			m_last_q <= done_s2;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;
	assign m_axis_tlast  = m_last_q;

endmodule

`default_nettype wire
